// File: rtl/core/rlp_pkg.sv
// ----------------------------------------------------------------------------
// rlp_pkg
// Shared constants, codes and types of the ramped linear panner.
// ----------------------------------------------------------------------------
package rlp_pkg;

  localparam int SAMPLE_BITS_DEF    = 24;
  localparam int GAIN_FRAC_BITS_DEF = 16;

  localparam int LEN_BITS     = 16;
  localparam int BAL_BITS     = 17;
  localparam int CFG_BITS     = 16;
  localparam int CFG_IDX_BITS = 1;

  localparam logic [CFG_BITS-1:0] DEFAULT_FADE_RST = 16'd882;
  localparam logic [CFG_BITS-1:0] MIN_FADE_RST     = 16'd220;

  localparam logic [CFG_IDX_BITS-1:0] CFG_DEFAULT_FADE = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_FADE     = 1'd1;

  typedef enum logic [1:0] {
    MODE_SAMPLE  = 2'd0,
    MODE_BAL     = 2'd1,
    MODE_BAL_LEN = 2'd2
  } mode_e;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

// File: rtl/core/rlp_in_if.sv
// ----------------------------------------------------------------------------
// rlp_in_if
// Input item channel: mode, mono sample, balance and fade length.
// ----------------------------------------------------------------------------
interface rlp_in_if #(
  parameter int SAMPLE_BITS = rlp_pkg::SAMPLE_BITS_DEF
);
  import rlp_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [1:0]                    mode;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic [BAL_BITS-1:0]           balance;
  logic [LEN_BITS-1:0]           fade_length;

  modport source (output valid, output mode, output sample, output balance,
                  output fade_length, input ready);
  modport sink   (input valid, input mode, input sample, input balance,
                  input fade_length, output ready);
endinterface

// File: rtl/core/rlp_out_if.sv
// ----------------------------------------------------------------------------
// rlp_out_if
// Result item channel: left and right scaled samples.
// ----------------------------------------------------------------------------
interface rlp_out_if #(
  parameter int SAMPLE_BITS = rlp_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

// File: rtl/core/rlp_mul.sv
// ----------------------------------------------------------------------------
// rlp_mul
// Bit-serial shift-add multiplier: signed A times unsigned B, one bit of B
// per cycle, LSB first. The product holds until the next start.
// ----------------------------------------------------------------------------
module rlp_mul #(
  parameter int AW = 18,
  parameter int BW = 17
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [AW-1:0]    a_i,
  input  logic [BW-1:0]           b_i,
  output logic signed [AW+BW-1:0] p_o,
  output rlp_pkg::unit_sts_t      sts_o
);
  import rlp_pkg::*;

  localparam int CNTW = $clog2(BW + 1);

  logic [AW-1:0]   a_q;
  logic [AW:0]     acc_q;
  logic [BW-1:0]   lo_q;
  logic [CNTW-1:0] cnt_q;
  logic            done_q;
  logic [AW:0]     sum;

  assign sum = acc_q + (lo_q[0] ? {a_q[AW-1], a_q} : {(AW + 1){1'b0}});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CNTW'(BW);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - 1'b1;
      done_q <= (cnt_q == CNTW'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      acc_q <= '0;
      lo_q  <= b_i;
    end else if (cnt_q != '0) begin
      acc_q <= {sum[AW], sum[AW:1]};
      lo_q  <= {sum[0], lo_q[BW-1:1]};
    end
  end

  assign p_o        = {acc_q[AW-1:0], lo_q};
  assign sts_o.busy = (cnt_q != '0);
  assign sts_o.done = done_q;

endmodule

// File: rtl/core/rlp_div.sv
// ----------------------------------------------------------------------------
// rlp_div
// Restoring radix-2 divider: signed dividend by unsigned divisor, one
// quotient bit per cycle, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module rlp_div #(
  parameter int NW = 33,
  parameter int QW = 18,
  parameter int LB = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [NW:0]        x_i,
  input  logic [LB-1:0]      d_i,
  output logic [QW-1:0]      q_o,
  output rlp_pkg::unit_sts_t sts_o
);
  import rlp_pkg::*;

  localparam int CNTW = $clog2(NW + 1);

  logic            neg_q;
  logic [NW-1:0]   quo_q;
  logic [LB-1:0]   rem_q;
  logic [LB-1:0]   d_q;
  logic [CNTW-1:0] cnt_q;
  logic            done_q;

  logic [NW:0]     mag;
  logic [LB:0]     shifted;
  logic [LB:0]     trial;
  logic            ge;
  logic [NW-1:0]   qs;

  assign mag     = x_i[NW] ? (~x_i + 1'b1) : x_i;
  assign shifted = {rem_q, quo_q[NW-1]};
  assign trial   = shifted - {1'b0, d_q};
  assign ge      = (shifted >= {1'b0, d_q});
  assign qs      = neg_q ? (~quo_q + 1'b1) : quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CNTW'(NW);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - 1'b1;
      done_q <= (cnt_q == CNTW'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= x_i[NW];
      quo_q <= mag[NW-1:0];
      rem_q <= '0;
      d_q   <= d_i;
    end else if (cnt_q != '0) begin
      rem_q <= ge ? trial[LB-1:0] : shifted[LB-1:0];
      quo_q <= {quo_q[NW-2:0], ge};
    end
  end

  assign q_o        = qs[QW-1:0];
  assign sts_o.busy = (cnt_q != '0);
  assign sts_o.done = done_q;

endmodule

// File: rtl/core/ramped_linear_panner.sv
// ----------------------------------------------------------------------------
// ramped_linear_panner
// Pans a mono sample stream into left and right with linearly ramped gains.
// Gains are unsigned Q1.GAIN_FRAC_BITS and reset to one half. A balance item
// (mode 1, or mode 2 with a fade length that is taken only while no ramp
// runs and is raised to the minimum) is taken in the idle state and starts
// ramps from the present gains toward the clipped balance (right) and one
// minus it (left). A sample item while a ramp runs computes each gain as
// start + (target - start) * elapsed / length in a bit-serial multiplier
// and a radix-2 divider per side, then scales the sample in the same
// multiplier. A sample item with no ramp step, or on the last ramp sample,
// only scales. The input is ready only in the idle state, so one item is
// in flight at a time. The result register lets the next item in while a
// result still waits to be taken.
// ----------------------------------------------------------------------------
module ramped_linear_panner #(
  parameter int SAMPLE_BITS    = rlp_pkg::SAMPLE_BITS_DEF,
  parameter int GAIN_FRAC_BITS = rlp_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  rlp_in_if.sink                            in_if,
  rlp_out_if.source                         out_if,
  input  logic                              cfg_we_i,
  input  logic [rlp_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [rlp_pkg::CFG_BITS-1:0]      cfg_data_i
);
  import rlp_pkg::*;

  localparam int GW  = GAIN_FRAC_BITS + 1;
  localparam int DFW = GW + 1;
  localparam int AW  = (DFW > SAMPLE_BITS) ? DFW : SAMPLE_BITS;
  localparam int BW  = (LEN_BITS > GW) ? LEN_BITS : GW;
  localparam int PW  = AW + BW;
  localparam int NW  = GW + LEN_BITS;
  localparam int CW  = (BAL_BITS > GW) ? BAL_BITS : GW;

  localparam int LEFT  = 0;
  localparam int RIGHT = 1;

  localparam logic [GW-1:0] GainOne  = {1'b1, {GAIN_FRAC_BITS{1'b0}}};
  localparam logic [GW-1:0] GainHalf = {2'b01, {(GAIN_FRAC_BITS - 1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INT_MUL,
    ST_INT_DIV,
    ST_SC_GO,
    ST_SC_MUL,
    ST_WR
  } state_e;

  state_e                  state_q;
  logic [CFG_BITS-1:0]     def_fade_q;
  logic [CFG_BITS-1:0]     min_fade_q;
  logic [GW-1:0]           gain_q   [2];
  logic [GW-1:0]           start_q  [2];
  logic [GW-1:0]           target_q [2];
  logic [LEN_BITS-1:0]     rem_q;
  logic [LEN_BITS-1:0]     len_q;
  logic                    out_vld_q;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic signed [SAMPLE_BITS-1:0] left_q;
  logic signed [SAMPLE_BITS-1:0] right_q;

  logic                    in_acc;
  logic                    wr_fire;
  logic                    out_vld_d;
  logic [CW-1:0]           bal_ext;
  logic [GW-1:0]           bal_clip;
  logic [GW-1:0]           tgt_new  [2];
  logic [LEN_BITS-1:0]     req_len;
  logic [LEN_BITS-1:0]     len_new;
  logic [LEN_BITS-1:0]     elapsed;
  logic                    mul_start;
  logic                    div_start;

  logic signed [DFW-1:0]   diff     [2];
  logic signed [AW-1:0]    mul_a    [2];
  logic [BW-1:0]           mul_b    [2];
  logic signed [PW-1:0]    mul_p    [2];
  logic [DFW-1:0]          div_q    [2];
  logic [DFW-1:0]          gain_sum [2];
  logic [GW-1:0]           gain_int [2];
  logic [SAMPLE_BITS-1:0]  scaled   [2];
  unit_sts_t               mul_sts  [2];
  unit_sts_t               div_sts  [2];

  assign in_if.ready = (state_q == ST_IDLE);
  assign in_acc      = in_if.valid && (state_q == ST_IDLE);
  assign wr_fire     = (state_q == ST_WR) && (!out_vld_q || out_if.ready);
  assign out_vld_d   = wr_fire || (out_vld_q && !out_if.ready);

  assign bal_ext  = CW'(in_if.balance);
  assign bal_clip = (bal_ext > CW'(GainOne)) ? GainOne : bal_ext[GW-1:0];
  assign tgt_new[RIGHT] = bal_clip;
  assign tgt_new[LEFT]  = GainOne - bal_clip;

  assign req_len = (in_if.fade_length < min_fade_q) ? min_fade_q : in_if.fade_length;
  assign len_new = ((mode_e'(in_if.mode) == MODE_BAL_LEN) && (rem_q == '0)) ? req_len : len_q;
  assign elapsed = (len_q > rem_q) ? (len_q - rem_q) : '0;

  assign mul_start = (in_acc && (mode_e'(in_if.mode) == MODE_SAMPLE) &&
                      (rem_q > LEN_BITS'(1))) || (state_q == ST_SC_GO);
  assign div_start = (state_q == ST_INT_MUL) && mul_sts[LEFT].done;

  for (genvar i = 0; i < 2; i++) begin : g_lane
    assign diff[i]  = {1'b0, target_q[i]} - {1'b0, start_q[i]};
    assign mul_a[i] = (state_q == ST_SC_GO) ? AW'(sample_q) : AW'(diff[i]);
    assign mul_b[i] = (state_q == ST_SC_GO) ? BW'(gain_q[i]) : BW'(elapsed);

    rlp_mul #(
      .AW (AW),
      .BW (BW)
    ) u_mul (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (mul_start),
      .a_i     (mul_a[i]),
      .b_i     (mul_b[i]),
      .p_o     (mul_p[i]),
      .sts_o   (mul_sts[i])
    );

    rlp_div #(
      .NW (NW),
      .QW (DFW),
      .LB (LEN_BITS)
    ) u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (div_start),
      .x_i     (mul_p[i][NW:0]),
      .d_i     (len_q),
      .q_o     (div_q[i]),
      .sts_o   (div_sts[i])
    );

    assign gain_sum[i] = {1'b0, start_q[i]} + div_q[i];
    assign gain_int[i] = gain_sum[i][GW-1:0];
    assign scaled[i]   = mul_p[i][GAIN_FRAC_BITS +: SAMPLE_BITS];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      def_fade_q <= DEFAULT_FADE_RST;
      min_fade_q <= MIN_FADE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DEFAULT_FADE: def_fade_q <= cfg_data_i;
        CFG_MIN_FADE:     min_fade_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
      rem_q     <= '0;
      len_q     <= DEFAULT_FADE_RST;
      for (int i = 0; i < 2; i++) begin
        gain_q[i]   <= GainHalf;
        start_q[i]  <= '0;
        target_q[i] <= '0;
      end
    end else begin
      out_vld_q <= out_vld_d;
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            case (mode_e'(in_if.mode))
              MODE_BAL, MODE_BAL_LEN: begin
                len_q <= len_new;
                rem_q <= len_new;
                for (int i = 0; i < 2; i++) begin
                  start_q[i]  <= gain_q[i];
                  target_q[i] <= tgt_new[i];
                  if (len_new == '0) begin
                    gain_q[i] <= tgt_new[i];
                  end
                end
              end
              MODE_SAMPLE: begin
                if (rem_q > LEN_BITS'(1)) begin
                  state_q <= ST_INT_MUL;
                end else begin
                  if (rem_q == LEN_BITS'(1)) begin
                    rem_q <= '0;
                    for (int i = 0; i < 2; i++) begin
                      gain_q[i] <= target_q[i];
                    end
                  end
                  state_q <= ST_SC_GO;
                end
              end
              default: ;
            endcase
          end
        end
        ST_INT_MUL: begin
          if (mul_sts[LEFT].done) begin
            state_q <= ST_INT_DIV;
          end
        end
        ST_INT_DIV: begin
          if (div_sts[LEFT].done) begin
            rem_q <= rem_q - 1'b1;
            for (int i = 0; i < 2; i++) begin
              gain_q[i] <= gain_int[i];
            end
            state_q <= ST_SC_GO;
          end
        end
        ST_SC_GO: begin
          state_q <= ST_SC_MUL;
        end
        ST_SC_MUL: begin
          if (mul_sts[LEFT].done) begin
            state_q <= ST_WR;
          end
        end
        ST_WR: begin
          if (wr_fire) begin
            if (rem_q == '0) begin
              len_q <= def_fade_q;
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sample_q <= in_if.sample;
    end
    if (wr_fire) begin
      left_q  <= scaled[LEFT];
      right_q <= scaled[RIGHT];
    end
  end

  assign out_if.valid     = out_vld_q;
  assign out_if.left_out  = left_q;
  assign out_if.right_out = right_q;

`ifndef SYNTHESIS
  a_lanes_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mul_sts[LEFT] == mul_sts[RIGHT]) && (div_sts[LEFT] == div_sts[RIGHT]))
    else $error("left and right units out of step");

  a_result_from_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == ST_WR))
    else $error("result raised outside the write state");

  a_rem_le_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= len_q)
    else $error("ramp remaining exceeds ramp length");

  a_gain_le_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (gain_q[LEFT] <= GainOne) && (gain_q[RIGHT] <= GainOne))
    else $error("gain above one");

  a_idle_units_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!mul_sts[LEFT].busy && !div_sts[LEFT].busy))
    else $error("arithmetic unit busy while idle");
`endif

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ramped linear panner. Tracks the gain ramps
// of both sides per accepted item and compares every left/right pair the
// block returns. A short directed run covers sample extremes, balance
// clipping, ramp snap, fade clamping, fade ignored during a ramp, retrigger
// and the unused mode. Random phases follow under several fade settings,
// random stalls on both channels but in one phase, one long output stall.
// ----------------------------------------------------------------------------
module tb;
  import rlp_pkg::*;

  localparam int SW = SAMPLE_BITS_DEF;
  localparam int GF = GAIN_FRAC_BITS_DEF;
  localparam longint GAIN_ONE = longint'(1) << GF;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 100;
  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 600;
  localparam int N_PHASES = 6;
  localparam int PHASE_ITEMS = 271;
  localparam int unsigned DFLT_SET [N_PHASES] = '{4, 1, 20, 65535, 300, 1};
  localparam int unsigned MIN_SET [N_PHASES] = '{3, 1, 8, 65535, 1, 65535};

  typedef struct {
    logic [1:0]           mode;
    logic signed [SW-1:0] sample;
    logic [BAL_BITS-1:0]  balance;
    logic [LEN_BITS-1:0]  fade_length;
  } pan_in_t;

  typedef struct {
    logic signed [SW-1:0] left_out;
    logic signed [SW-1:0] right_out;
  } pan_pair_t;

  class pan_gain_model;
    int unsigned dflt_fade;
    int unsigned min_fade;
    longint left_gain, right_gain, left_from, right_from, left_to, right_to;
    int unsigned remaining;
    int unsigned ramp_len;
    pan_pair_t expected_pairs[$];
    int unsigned errors;

    function new();
      dflt_fade = DEFAULT_FADE_RST;
      min_fade = MIN_FADE_RST;
      left_gain = GAIN_ONE / 2;
      right_gain = GAIN_ONE / 2;
      left_from = 0;
      right_from = 0;
      left_to = 0;
      right_to = 0;
      remaining = 0;
      ramp_len = dflt_fade;
      errors = 0;
    endfunction

    function void set_register(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] val);
      if (idx == CFG_DEFAULT_FADE) dflt_fade = val;
      else if (idx == CFG_MIN_FADE) min_fade = val;
    endfunction

    function longint lerp(longint from_g, longint to_g, int unsigned el, int unsigned len);
      longint span;
      span = to_g - from_g;
      if (len == 0) return to_g;
      return from_g + (span * longint'(el)) / longint'(len);
    endfunction

    function logic signed [SW-1:0] scale_side(logic signed [SW-1:0] s, longint g);
      longint prod;
      prod = longint'(s) * g;
      return SW'(prod >>> GF);
    endfunction

    function void absorb_item(pan_in_t it);
      longint bal;
      int unsigned el;
      pan_pair_t res;
      if (it.mode == MODE_BAL || it.mode == MODE_BAL_LEN) begin
        bal = longint'(it.balance);
        if (it.mode == MODE_BAL_LEN && remaining == 0)
          ramp_len = (it.fade_length < min_fade) ? min_fade : it.fade_length;
        if (bal > GAIN_ONE) bal = GAIN_ONE;
        right_from = right_gain;
        left_from = left_gain;
        right_to = bal;
        left_to = GAIN_ONE - bal;
        remaining = ramp_len;
        if (ramp_len == 0) begin
          right_gain = right_to;
          left_gain = left_to;
        end
      end else if (it.mode == MODE_SAMPLE) begin
        if (remaining > 0) begin
          if (remaining == 1) begin
            right_gain = right_to;
            left_gain = left_to;
          end else begin
            el = (ramp_len > remaining) ? ramp_len - remaining : 0;
            right_gain = lerp(right_from, right_to, el, ramp_len);
            left_gain = lerp(left_from, left_to, el, ramp_len);
          end
          remaining--;
        end
        res.left_out = scale_side(it.sample, left_gain);
        res.right_out = scale_side(it.sample, right_gain);
        expected_pairs.push_back(res);
        if (remaining == 0) ramp_len = dflt_fade;
      end
    endfunction

    function void compare_pair(logic signed [SW-1:0] l, logic signed [SW-1:0] r);
      pan_pair_t e;
      if (expected_pairs.size() == 0) begin
        $display("%0t: unexpected result left %0d right %0d", $time, l, r);
        errors++;
        return;
      end
      e = expected_pairs.pop_front();
      if (l !== e.left_out) begin
        $display("%0t: left_out expected %0d got %0d", $time, e.left_out, l);
        errors++;
      end
      if (r !== e.right_out) begin
        $display("%0t: right_out expected %0d got %0d", $time, e.right_out, r);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_pairs.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_BITS-1:0] cfg_idx_i;
  logic [CFG_BITS-1:0] cfg_data_i;
  bit no_idle;
  int unsigned results_seen;
  int unsigned stall_cnt;
  pan_gain_model gains = new();

  rlp_in_if in_ch();
  rlp_out_if out_ch();

  ramped_linear_panner dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_ch),
    .out_if     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic send_item(input pan_in_t it);
    while (!no_idle && $urandom_range(99) < 37) begin
      in_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid = 1'b1;
    in_ch.mode = it.mode;
    in_ch.sample = it.sample;
    in_ch.balance = it.balance;
    in_ch.fade_length = it.fade_length;
    do @(posedge clk_i); while (!in_ch.ready);
    gains.absorb_item(it);
    @(negedge clk_i);
  endtask

  task automatic offer(input logic [1:0] mode, input int sample, input int unsigned bal,
                       input int unsigned fade);
    pan_in_t it;
    it.mode = mode;
    it.sample = SW'(sample);
    it.balance = BAL_BITS'(bal);
    it.fade_length = LEN_BITS'(fade);
    send_item(it);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    gains.set_register(idx, val);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic wait_drained();
    while (gains.pending() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  function automatic pan_in_t rand_item();
    pan_in_t it;
    int unsigned pick;
    pick = $urandom_range(99);
    it.mode = MODE_SAMPLE;
    if (pick < 8) it.mode = MODE_BAL;
    else if (pick < 14) it.mode = MODE_BAL_LEN;
    else if (pick < 17) it.mode = MODE_UNUSED;
    case ($urandom_range(9))
      0: it.sample = {1'b0, {(SW-1){1'b1}}};
      1: it.sample = {1'b1, {(SW-1){1'b0}}};
      2: it.sample = SW'(int'($urandom_range(6)) - 3);
      default: it.sample = SW'($urandom);
    endcase
    case ($urandom_range(9))
      0: it.balance = '0;
      1: it.balance = BAL_BITS'(GAIN_ONE);
      2: it.balance = BAL_BITS'($urandom_range(131071, 65537));
      3: it.balance = BAL_BITS'($urandom);
      default: it.balance = BAL_BITS'($urandom_range(65536));
    endcase
    case ($urandom_range(49))
      0: it.fade_length = '0;
      1: it.fade_length = '1;
      2: it.fade_length = LEN_BITS'($urandom);
      default: it.fade_length = LEN_BITS'($urandom_range(40));
    endcase
    return it;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      gains.compare_pair(out_ch.left_out, out_ch.right_out);
      results_seen++;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)))
      stall_cnt = 0;
    else
      stall_cnt++;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!hold_done && results_seen >= 150) begin
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_done = 1'b1;
      end
      out_ch.ready = no_idle || ($urandom_range(99) >= 37);
    end
  end

  initial begin
    pan_in_t it;
    int unsigned counted;
    rst_ni = 1'b0;
    no_idle = 1'b0;
    results_seen = 0;
    stall_cnt = 0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_SAMPLE;
    in_ch.sample = '0;
    in_ch.balance = '0;
    in_ch.fade_length = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    write_cfg(CFG_DEFAULT_FADE, 16'd4);
    write_cfg(CFG_MIN_FADE, 16'd3);
    offer(MODE_SAMPLE, 8388607, 0, 0);
    offer(MODE_SAMPLE, -8388608, 0, 0);
    offer(MODE_SAMPLE, -1, 0, 0);
    offer(MODE_UNUSED, 4242, 65536, 7);
    offer(MODE_BAL_LEN, 0, 131071, 0);
    offer(MODE_SAMPLE, 8388607, 0, 0);
    offer(MODE_SAMPLE, -8388608, 0, 0);
    offer(MODE_SAMPLE, -1, 0, 0);
    offer(MODE_SAMPLE, 12345, 0, 0);
    offer(MODE_BAL_LEN, 0, 0, 10);
    offer(MODE_SAMPLE, 1000000, 0, 0);
    offer(MODE_SAMPLE, -777, 0, 0);
    offer(MODE_BAL_LEN, 0, 65536, 2);
    repeat (3) offer(MODE_SAMPLE, -8388608, 0, 0);
    offer(MODE_BAL, 0, 32768, 65535);
    repeat (9) offer(MODE_SAMPLE, 8388607, 0, 0);
    in_ch.valid = 1'b0;

    for (int p = 0; p < N_PHASES; p++) begin
      wait_drained();
      write_cfg(CFG_DEFAULT_FADE, CFG_BITS'(DFLT_SET[p]));
      write_cfg(CFG_MIN_FADE, CFG_BITS'(MIN_SET[p]));
      no_idle = (p == 2);
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        it = rand_item();
        send_item(it);
        if (it.mode != MODE_UNUSED) counted++;
      end
      in_ch.valid = 1'b0;
    end
    no_idle = 1'b0;

    wait_drained();
    if (gains.errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
